// File: src/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types, field widths, item and status codes, and the rule index
// function of the Turing machine stepper.
// ----------------------------------------------------------------------------
package tms_pkg;

    // field widths of the beats
    localparam int KIND_W  = 2;
    localparam int EIDX_W  = 6;
    localparam int SYM_W   = 4;
    localparam int MST_W   = 4;
    localparam int CADDR_W = 9;
    localparam int STAT_W  = 3;
    localparam int HEAD_W  = 9;
    localparam int CNT_W   = 32;
    localparam int SHELL_W = 10;

    // default sizes of the two stores
    localparam int TAPE_CELLS_DEF    = 512;
    localparam int TABLE_ENTRIES_DEF = 64;

    // item kinds
    localparam logic [KIND_W-1:0] K_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] K_STEP = 2'd1;
    localparam logic [KIND_W-1:0] K_READ = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE           = 3'd0;
    localparam logic [STAT_W-1:0] ST_STEPPED        = 3'd1;
    localparam logic [STAT_W-1:0] ST_HALTED_NOW     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY_HALTED = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_RULE        = 3'd4;
    localparam logic [STAT_W-1:0] ST_OFF_TAPE       = 3'd5;

    // one rule table entry, msb first
    typedef struct packed {
        logic [MST_W-1:0] goto_state;
        logic             halts;
        logic             moves_right;
        logic [SYM_W-1:0] wr_sym;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

    // result beat payload
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SYM_W-1:0]  read_symbol;
        logic [MST_W-1:0]  state_before;
        logic [HEAD_W-1:0] head_after;
        logic [MST_W-1:0]  state_after;
        logic [CNT_W-1:0]  steps_done;
        logic [SYM_W-1:0]  cell_value;
    } t_result;

    // square-shell index: (m-1)^2 + 2*(st+sym) + (st<sym) - 1, zero when m is zero
    function automatic logic [SHELL_W-1:0] shell_index(
        input logic [MST_W-1:0] st,
        input logic [SYM_W-1:0] sym
    );
        logic [3:0]         m;
        logic [3:0]         mm1;
        logic [7:0]         sq;
        logic [4:0]         sum;
        logic [SHELL_W-1:0] idx;
        m   = (st > sym) ? st : sym;
        mm1 = m - 4'd1;
        sq  = {4'b0, mm1} * {4'b0, mm1};
        sum = {1'b0, st} + {1'b0, sym};
        idx = {2'b0, sq} + {4'b0, sum, 1'b0} + {9'b0, (st < sym)} - 10'd1;
        if (m == 4'd0) begin
            idx = '0;
        end
        return idx;
    endfunction

endpackage

// File: src/tms_if.sv
// ----------------------------------------------------------------------------
// tms_if
// Valid/ready channels of the stepper: the item channel and the result
// channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
interface tms_in_if;
    logic                         valid;
    logic                         ready;
    logic [tms_pkg::KIND_W-1:0]   kind;
    logic [tms_pkg::EIDX_W-1:0]   entry_index;
    logic [tms_pkg::SYM_W-1:0]    entry_write_symbol;
    logic                         entry_moves_right;
    logic                         entry_halts;
    logic [tms_pkg::MST_W-1:0]    entry_next_state;
    logic [tms_pkg::CADDR_W-1:0]  cell_address;

    modport source (
        output valid, kind, entry_index, entry_write_symbol, entry_moves_right,
               entry_halts, entry_next_state, cell_address,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_write_symbol, entry_moves_right,
               entry_halts, entry_next_state, cell_address,
        output ready
    );
endinterface

interface tms_out_if;
    logic                        valid;
    logic                        ready;
    logic [tms_pkg::STAT_W-1:0]  status;
    logic [tms_pkg::SYM_W-1:0]   read_symbol;
    logic [tms_pkg::MST_W-1:0]   state_before;
    logic [tms_pkg::HEAD_W-1:0]  head_after;
    logic [tms_pkg::MST_W-1:0]   state_after;
    logic [tms_pkg::CNT_W-1:0]   steps_done;
    logic [tms_pkg::SYM_W-1:0]   cell_value;

    modport source (
        output valid, status, read_symbol, state_before, head_after, state_after,
               steps_done, cell_value,
        input  ready
    );
    modport sink (
        input  valid, status, read_symbol, state_before, head_after, state_after,
               steps_done, cell_value,
        output ready
    );
endinterface

// File: src/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while no read is issued.
// ----------------------------------------------------------------------------
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: src/turing_machine_stepper_core.sv
// A step reads the tape, reads the rule, then writes the tape back and registers
// its result; a read reads the tape, a load writes the rule table, an unused kind does nothing.
// One item at a time: no new item is taken until the last one's result is
// registered, and a result still held by the sink stalls that finish.
// Reset: head to the tape center, state, halt flag and count to zero; then a
// clearing pass zeroes every tape cell, and no item is taken meanwhile.
// ----------------------------------------------------------------------------
// turing_machine_stepper_core
// Turing machine stepper: rule table and tape in synchronous RAMs, a small
// sequencer reads the tape, reads the rule, then writes the tape back.
// ----------------------------------------------------------------------------
module turing_machine_stepper_core #(
    parameter int TAPE_CELLS    = tms_pkg::TAPE_CELLS_DEF,
    parameter int TABLE_ENTRIES = tms_pkg::TABLE_ENTRIES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tms_in_if.sink    i_in,
    tms_out_if.source o_out
);
    import tms_pkg::*;

    localparam int TH_W = $clog2(TAPE_CELLS);
    localparam int TR_W = $clog2(TABLE_ENTRIES);
    localparam logic [TH_W-1:0] HEAD_LAST   = TH_W'(TAPE_CELLS - 1);
    localparam logic [TH_W-1:0] HEAD_CENTER = TH_W'(TAPE_CELLS / 2);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_TAPE  = 5'b00100,
        S_RULE  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [TH_W-1:0]    r_clr_addr, n_clr_addr;
    logic [TH_W-1:0]    r_head, n_head;
    logic [MST_W-1:0]   r_mstate, n_mstate;
    logic               r_halted, n_halted;
    logic [CNT_W-1:0]   r_steps, n_steps;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic               r_cell_ok, n_cell_ok;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [SYM_W-1:0]   r_cell, n_cell;
    logic [STAT_W-1:0]  r_fin_status, n_fin_status;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               in_fire;
    logic               out_free;
    logic               finish;
    logic [STAT_W-1:0]  fin_status;
    logic [SHELL_W-1:0] shell_idx;

    logic               tape_we, tape_rd_en;
    logic [TH_W-1:0]    tape_wr_addr, tape_rd_addr;
    logic [SYM_W-1:0]   tape_wr_data, tape_rd_data;
    logic               rule_we, rule_rd_en;
    logic [TR_W-1:0]    rule_wr_addr, rule_rd_addr;
    t_rule              rule_wr_data, rule_rd_data;

    tms_ram #(.WIDTH(SYM_W), .DEPTH(TAPE_CELLS)) u_tape (
        .i_clk     (i_clk),
        .i_we      (tape_we),
        .i_wr_addr (tape_wr_addr),
        .i_wr_data (tape_wr_data),
        .i_rd_en   (tape_rd_en),
        .i_rd_addr (tape_rd_addr),
        .o_rd_data (tape_rd_data)
    );

    tms_ram #(.WIDTH(RULE_W), .DEPTH(TABLE_ENTRIES)) u_rule (
        .i_clk     (i_clk),
        .i_we      (rule_we),
        .i_wr_addr (rule_wr_addr),
        .i_wr_data (rule_wr_data),
        .i_rd_en   (rule_rd_en),
        .i_rd_addr (rule_rd_addr),
        .o_rd_data (rule_rd_data)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign shell_idx  = shell_index(r_mstate, tape_rd_data);

    // accesses never overlap: the tape write of a step lands before the next
    // beat is taken, and a rule load lands before any later beat is taken
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_head       = r_head;
        n_mstate     = r_mstate;
        n_halted     = r_halted;
        n_steps      = r_steps;
        n_kind       = r_kind;
        n_cell_ok    = r_cell_ok;
        n_sym        = r_sym;
        n_cell       = r_cell;
        n_fin_status = r_fin_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        finish       = 1'b0;
        fin_status   = r_fin_status;

        tape_we      = 1'b0;
        tape_wr_addr = r_head;
        tape_wr_data = rule_rd_data.wr_sym;
        tape_rd_en   = 1'b0;
        tape_rd_addr = r_head;
        rule_we      = 1'b0;
        rule_wr_addr = TR_W'(i_in.entry_index);
        rule_wr_data = '{goto_state:   i_in.entry_next_state,
                         halts:        i_in.entry_halts,
                         moves_right:  i_in.entry_moves_right,
                         wr_sym:       i_in.entry_write_symbol};
        rule_rd_en   = 1'b0;
        rule_rd_addr = TR_W'(shell_idx);

        case (r_state)
            S_CLEAR: begin
                tape_we      = 1'b1;
                tape_wr_addr = r_clr_addr;
                tape_wr_data = '0;
                n_clr_addr   = r_clr_addr + 1'b1;
                if (r_clr_addr == HEAD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_kind       = i_in.kind;
                    n_fin_status = ST_DONE;
                    case (i_in.kind)
                        K_LOAD: begin
                            rule_we = (32'(i_in.entry_index) < 32'(TABLE_ENTRIES));
                            n_state = S_FIN;
                        end
                        K_STEP: begin
                            tape_rd_en = 1'b1;
                            n_state    = S_TAPE;
                        end
                        K_READ: begin
                            tape_rd_en   = 1'b1;
                            tape_rd_addr = TH_W'(i_in.cell_address);
                            n_cell_ok    = (32'(i_in.cell_address) < 32'(TAPE_CELLS));
                            n_state      = S_TAPE;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_TAPE: begin
                n_state = S_FIN;
                if (r_kind == K_READ) begin
                    n_cell = tape_rd_data;
                end else begin
                    n_sym = tape_rd_data;
                    if (r_halted) begin
                        n_fin_status = ST_ALREADY_HALTED;
                    end else if (32'(shell_idx) >= 32'(TABLE_ENTRIES)) begin
                        n_fin_status = ST_NO_RULE;
                    end else begin
                        rule_rd_en = 1'b1;
                        n_state    = S_RULE;
                    end
                end
            end
            S_RULE: begin
                if (out_free) begin
                    finish = 1'b1;
                    if (rule_rd_data.moves_right ? (r_head == HEAD_LAST)
                                                 : (r_head == '0)) begin
                        fin_status = ST_OFF_TAPE;
                    end else begin
                        tape_we = 1'b1;
                        n_head  = rule_rd_data.moves_right ? r_head + 1'b1
                                                           : r_head - 1'b1;
                        if (rule_rd_data.halts) begin
                            n_halted   = 1'b1;
                            fin_status = ST_HALTED_NOW;
                        end else begin
                            n_mstate   = rule_rd_data.goto_state;
                            n_steps    = (r_steps == '1) ? r_steps : r_steps + 1'b1;
                            fin_status = ST_STEPPED;
                        end
                    end
                end
            end
            S_FIN: begin
                finish = out_free;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_out       = '{status:       fin_status,
                            read_symbol:  (r_kind == K_STEP) ? r_sym : '0,
                            state_before: r_mstate,
                            head_after:   HEAD_W'(n_head),
                            state_after:  n_mstate,
                            steps_done:   n_steps,
                            cell_value:   (r_kind == K_READ && r_cell_ok) ? r_cell : '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= HEAD_CENTER;
            r_mstate    <= '0;
            r_halted    <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_mstate    <= n_mstate;
            r_halted    <= n_halted;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_cell_ok    <= n_cell_ok;
        r_sym        <= n_sym;
        r_cell       <= n_cell;
        r_fin_status <= n_fin_status;
        r_out        <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.read_symbol  = r_out.read_symbol;
    assign o_out.state_before = r_out.state_before;
    assign o_out.head_after   = r_out.head_after;
    assign o_out.state_after  = r_out.state_after;
    assign o_out.steps_done   = r_out.steps_done;
    assign o_out.cell_value   = r_out.cell_value;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("item taken during tape clearing pass");

    a_tape_write_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tape_we |-> (r_state == S_RULE || r_state == S_CLEAR))
        else $error("tape written outside write-back or clearing");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_steps >= $past(r_steps)))
        else $error("step count went down");

    a_halt_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_HALTED_NOW) |-> r_halted)
        else $error("halted beat shown while machine not halted");
endmodule
